@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Item layouts for both channels, the stored entry, the cell control group,
// and the opcode and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] item_tag;
    logic [6:0]  item_age;
    logic [7:0]  item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [6:0]  out_age;
    logic [7:0]  out_priority;
    logic [4:0]  occupancy_now;
  } spq_out_t;

  // One stored entry
  typedef struct packed {
    logic [15:0] tag;
    logic [6:0]  age;
    logic [7:0]  pri;
  } spq_entry_t;

  // Broadcast to every cell for the current item
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_ctl_t;

endpackage

@@ sv/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry. On insert it keeps, takes the new entry, or takes its
// left neighbor's entry; on pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic               clk_i,
  input  spq_pkg::spq_ctl_t  ctl_i,
  input  spq_pkg::spq_entry_t new_i,
  input  spq_pkg::spq_entry_t left_i,
  input  spq_pkg::spq_entry_t right_i,
  input  logic               left_before_i,
  input  logic               occupied_i,
  output logic               before_o,
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q;

  // The new entry belongs at or ahead of this slot. The head yields only to a
  // strictly higher priority; later slots also yield on equal priority.
  always_comb begin
    if (!occupied_i) begin
      before_o = 1'b1;
    end else if (IS_HEAD) begin
      before_o = entry_q.pri < new_i.pri;
    end else begin
      before_o = entry_q.pri <= new_i.pri;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      if (left_before_i) begin
        entry_q <= left_i;
      end else if (before_o) begin
        entry_q <= new_i;
      end
    end else if (ctl_i.pop) begin
      entry_q <= right_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ sv/sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue in a row of cells
// Input channel (in_valid_i / in_ready_o / in_data_i) carries an opcode:
// insert places the entry in descending priority order, pop returns the head.
// Each item gives exactly one result on out_valid_o / out_ready_i / out_data_o
// with a status: done, insert refused (full) or pop refused (empty).
// The result is registered at the edge that accepts the item. One item is
// taken per cycle unless results stall; every cell compares its entry with
// the new priority in parallel and all shift left or right at that edge.
// While a result waits unaccepted, in_ready_o is low unless out_ready_i is
// high, so the next item is taken in the same cycle the result leaves.
// Reset empties the queue (occupancy zero) and clears the output valid; the
// entry storage is not cleared and holds no meaning until written.
// DEPTH sets the number of cells (2 to 256); occupancy_now reports the low
// five bits of the entry count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int OccW = $clog2(DEPTH + 1);

  logic [OccW-1:0] occ_q, occ_d;
  logic            out_valid_q;
  spq_out_t        out_q;

  logic       accept, full, empty;
  spq_ctl_t   ctl;
  spq_entry_t new_entry;
  spq_entry_t cell_entry [DEPTH];
  logic       cell_before [DEPTH];
  logic [OccW+4:0] occ_wide;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (occ_q == OccW'(DEPTH));
  assign empty      = (occ_q == '0);

  assign ctl.ins = accept && (in_data_i.opcode == OP_INSERT) && !full;
  assign ctl.pop = accept && (in_data_i.opcode == OP_POP) && !empty;

  assign new_entry.tag = in_data_i.item_tag;
  assign new_entry.age = in_data_i.item_age;
  assign new_entry.pri = in_data_i.item_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_e, right_e;
    logic       left_b;

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_b = 1'b0;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_b = cell_before[i-1];
    end

    // The last cell's refill on pop lands beyond the new occupancy
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    spq_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .new_i         (new_entry),
      .left_i        (left_e),
      .right_i       (right_e),
      .left_before_i (left_b),
      .occupied_i    (OccW'(i) < occ_q),
      .before_o      (cell_before[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (ctl.ins) begin
      occ_d = occ_q + OccW'(1);
    end else if (ctl.pop) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  assign occ_wide = {5'd0, occ_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.occupancy_now <= occ_wide[4:0];
      out_q.out_tag       <= '0;
      out_q.out_age       <= '0;
      out_q.out_priority  <= '0;
      if (in_data_i.opcode == OP_INSERT) begin
        out_q.status <= full ? ST_FULL : ST_DONE;
      end else if (empty) begin
        out_q.status <= ST_EMPTY;
      end else begin
        out_q.status       <= ST_DONE;
        out_q.out_tag      <= cell_entry[0].tag;
        out_q.out_age      <= cell_entry[0].age;
        out_q.out_priority <= cell_entry[0].pri;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches accepted items, the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input spq_pkg::spq_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam logic [4:0] FullOcc = 5'(DEPTH);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // With no result pending the block takes an item
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  // An accepted insert gives a result next cycle with no entry payload
  a_ins_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.opcode == OP_INSERT |=>
      out_valid_o && out_data_o.status != ST_EMPTY && out_data_o.out_tag == '0
      && out_data_o.out_age == '0 && out_data_o.out_priority == '0)
    else $error("insert result inconsistent");

  // A refused pop leaves an empty queue and zero payload
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.occupancy_now == 5'd0 && out_data_o.out_tag == '0
      && out_data_o.out_age == '0 && out_data_o.out_priority == '0)
    else $error("empty pop result inconsistent");

  // A refused insert reports a full queue
  a_full_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.occupancy_now == FullOcc && out_data_o.out_tag == '0)
    else $error("full insert result inconsistent");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .DEPTH (DEPTH)
) u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
